FILE: rtl/idle_gap_frame_echo_assert.svh
// ----------------------------------------------------------------------------
// idle_gap_frame_echo assertion macros
// Shared assertion wrappers for the frame echo block; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef IDLE_GAP_FRAME_ECHO_ASSERT_SVH
`define IDLE_GAP_FRAME_ECHO_ASSERT_SVH

`ifndef SYNTH

// Condition holds at every edge out of reset.
`define IGFE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("igfe: invariant violated");

// Antecedent at one edge implies consequent at the next.
`define IGFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("igfe: sequence violated");

`else

`define IGFE_ASSERT_ALWAYS(lbl, expr)
`define IGFE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/igfe_pkg.sv
// ----------------------------------------------------------------------------
// igfe_pkg
// Types and constants shared by the idle gap frame echo block.
// ----------------------------------------------------------------------------
package igfe_pkg;

  localparam int unsigned FRAME_DEPTH_DEF = 64;
  localparam int unsigned GAP_W           = 16;
  localparam logic [GAP_W-1:0] GAP_RESET  = 16'd100;
  localparam logic [GAP_W-1:0] TIMER_MAX  = 16'hFFFF;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

endpackage

FILE: rtl/igfe_store.sv
// ----------------------------------------------------------------------------
// igfe_store
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module igfe_store #(
  parameter int unsigned FRAME_DEPTH = 64,
  localparam int unsigned AW = $clog2(FRAME_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/igfe_out.sv
// ----------------------------------------------------------------------------
// igfe_out
// Two-entry output queue; decouples store reads from downstream stalls.
// ----------------------------------------------------------------------------
module igfe_out
  import igfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  out_item_t  push_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  output logic [1:0] count
);

`include "idle_gap_frame_echo_assert.svh"

  out_item_t slot [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic      pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `IGFE_ASSERT_ALWAYS(a_no_overflow, !(push && count == 2'd2 && !pop))
  `IGFE_ASSERT_ALWAYS(a_count_range, count != 2'd3)
  `IGFE_ASSERT_NEXT(a_push_shows, push && count == 2'd0, out_valid)

endmodule

FILE: rtl/idle_gap_frame_echo.sv
// Input: a byte or tick is accepted while idle. After the tick that ends a frame,
// the first echoed byte passes the state register, the store read register and
// the output queue. Throughput: one input transaction per cycle while idle; an
// echo holds input off until the single store read port reads its last byte.
// Reset: synchronous; counts as idle, gap_ms returns to 100, store not cleared.
// ----------------------------------------------------------------------------
// idle_gap_frame_echo
// Groups received bytes into idle-gap frames and replays each frame once.
// ----------------------------------------------------------------------------
module idle_gap_frame_echo
  import igfe_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [GAP_W-1:0] cfg_data
);

`include "idle_gap_frame_echo_assert.svh"

  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned LW = $clog2(FRAME_DEPTH + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(FRAME_DEPTH);
  localparam logic [LW-1:0] LEN_ONE  = LW'(1);

  typedef enum logic {
    S_IDLE,
    S_REPLAY
  } state_t;

  state_t           state;
  logic [GAP_W-1:0] gap_ms;
  logic [GAP_W-1:0] idle_timer;
  logic [GAP_W-1:0] timer_inc;
  logic [LW-1:0]    frame_length;
  logic             frame_open;
  logic             echo_pending;
  logic [AW-1:0]    rd_idx;
  logic             inflight;
  logic             inflight_last;

  logic             accept;
  logic             byte_in;
  logic             tick_in;
  logic             new_frame;
  logic             append;
  logic             start_echo;
  logic             we;
  logic [AW-1:0]    waddr;
  logic             issue;
  logic             issue_last;
  logic [7:0]       rdata;
  logic [1:0]       q_count;
  logic             pop;
  out_item_t        push_data;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign byte_in   = accept && (in_data.opcode == OP_BYTE);
  assign tick_in   = accept && (in_data.opcode == OP_TICK);

  assign timer_inc  = (idle_timer == TIMER_MAX) ? idle_timer : idle_timer + 1'b1;
  assign new_frame  = !frame_open || (idle_timer >= gap_ms);
  assign append     = !new_frame && (frame_length < LEN_FULL);
  assign start_echo = tick_in && echo_pending && (timer_inc >= gap_ms);

  assign we    = byte_in && (new_frame || append);
  assign waddr = new_frame ? '0 : frame_length[AW-1:0];

  // Store writes happen only while idle and reads only while replaying.
  assign pop        = out_valid && out_ready;
  assign issue      = (state == S_REPLAY) &&
                      ({1'b0, q_count} + {2'b0, inflight} < 3'd2 + {2'b0, pop});
  assign issue_last = (LW'(rd_idx) + LEN_ONE) == frame_length;

  assign push_data.tx_byte = rdata;
  assign push_data.last    = inflight_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      gap_ms        <= GAP_RESET;
      idle_timer    <= '0;
      frame_length  <= '0;
      frame_open    <= 1'b0;
      echo_pending  <= 1'b0;
      rd_idx        <= '0;
      inflight      <= 1'b0;
      inflight_last <= 1'b0;
    end else begin
      if (cfg_valid) begin
        gap_ms <= cfg_data;
      end
      inflight      <= issue;
      inflight_last <= issue && issue_last;
      case (state)
        S_IDLE: begin
          if (byte_in) begin
            idle_timer   <= '0;
            frame_open   <= 1'b1;
            echo_pending <= 1'b1;
            if (new_frame) begin
              frame_length <= LEN_ONE;
            end else if (append) begin
              frame_length <= frame_length + LEN_ONE;
            end
          end else if (tick_in) begin
            idle_timer <= timer_inc;
            if (start_echo) begin
              echo_pending <= 1'b0;
              rd_idx       <= '0;
              state        <= S_REPLAY;
            end
          end
        end
        S_REPLAY: begin
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
            if (issue_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  igfe_store #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_data.rx_byte),
    .re    (issue),
    .raddr (rd_idx),
    .rdata (rdata)
  );

  igfe_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (inflight),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

  `IGFE_ASSERT_ALWAYS(a_write_idle, !we || state == S_IDLE)
  `IGFE_ASSERT_ALWAYS(a_len_bound, frame_length <= LEN_FULL)
  `IGFE_ASSERT_ALWAYS(a_pending_len, !echo_pending || frame_length != '0)
  `IGFE_ASSERT_NEXT(a_echo_start, start_echo, state == S_REPLAY && !echo_pending)
  `IGFE_ASSERT_NEXT(a_last_done, issue && issue_last, state == S_IDLE && inflight_last)

endmodule
